// ===== design/particle_sensor_frame_parser_defines.svh =====
// ----------------------------------------------------------------------------
// Particle sensor frame parser: assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/psfp_pkg.sv =====
// ----------------------------------------------------------------------------
// psfp_pkg
// Types and constants for the particle sensor frame parser.
// ----------------------------------------------------------------------------
package psfp_pkg;

    localparam logic [7:0] START_FIRST  = 8'h42;
    localparam logic [7:0] START_SECOND = 8'h4D;

    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] SHORT_LEN = 6'd24;
    localparam logic [POS_W-1:0] LONG_LEN  = 6'd32;

    localparam int unsigned NUM_WORDS = 6;
    localparam int unsigned WORD_W    = 16;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RX_ERR    = 3'd1,
        ST_BAD_START = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_SUM   = 3'd4
    } status_t;

endpackage

// ===== design/particle_sensor_frame_parser.sv =====
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// Byte-stream parser for particulate sensor frames with sum check.
// ----------------------------------------------------------------------------
// Usage:
//   s_*   : one request per received byte (tdata) or receive timeout (tuser).
//   m_*   : one request per finished frame or per error; status on tuser,
//           six 16-bit readings on tdata (zero for status 1, 2 and 3).
//   cfg_* : frame length select, 0 = 24 bytes, 1 = 32 bytes. Always ready;
//           the value is latched per frame at the first start byte.
// Timing:
//   One byte is taken every clock while m_* is not stalled. A result appears
//   on m_* in the cycle after the request that completes the frame or shows
//   the error. All per-byte work is a single add and compare between the parser
//   state and the output register: one request per cycle without a stall.
// Reset:
//   Parser hunts for the first start byte, output empty, 32-byte frames.
// Back-pressure:
//   While a result waits on m_* with m_tready low, s_tready drops; it rises
//   in the cycle the result is taken, so bytes keep flowing back to back.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser
    import psfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tuser,   // [0] rx_timeout

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // [15:0] pm1_indoor, [31:16] pm25_indoor,
                                    // [47:32] pm10_indoor, [63:48] pm1_outdoor,
                                    // [79:64] pm25_outdoor, [95:80] pm10_outdoor
    output logic [2:0]   m_tuser,   // [2:0] status

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data   // long_frame
);

    // Configuration and per-frame length
    logic long_cfg_reg, long_cfg_next;
    logic long_frm_reg, long_frm_next;

    // Parser state
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic [WORD_W-1:0] length_reg, length_next;
    logic [7:0]        hold_reg, hold_next;
    logic [WORD_W-1:0] words_reg  [NUM_WORDS];
    logic [WORD_W-1:0] words_next [NUM_WORDS];

    // Output register
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [95:0]       out_data_reg, out_data_next;

    logic              accept;
    logic              emit;
    status_t           res_status;
    logic              res_with_data;
    logic [POS_W-1:0]  frame_len;
    logic [POS_W-1:0]  pos_m5;
    logic [2:0]        word_idx;
    logic [WORD_W-1:0] word;
    logic [95:0]       words_flat;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign frame_len = long_frm_reg ? LONG_LEN : SHORT_LEN;
    assign pos_m5    = pos_reg - 6'd5;
    assign word_idx  = pos_m5[3:1];
    assign word      = {hold_reg, s_tdata};

    always_comb
    begin
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            words_flat[i*WORD_W +: WORD_W] = words_reg[i];
        end
    end

    // Per-byte parse
    always_comb
    begin
        long_cfg_next = long_cfg_reg;
        long_frm_next = long_frm_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        length_next   = length_reg;
        hold_next     = hold_reg;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            words_next[i] = words_reg[i];
        end
        emit          = 1'b0;
        res_status    = ST_OK;
        res_with_data = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            long_cfg_next = cfg_data;
        end

        if (accept)
        begin
            if (pos_reg == 6'd0)
            begin
                if (s_tuser)
                begin
                    emit       = 1'b1;
                    res_status = ST_RX_ERR;
                end
                else if (s_tdata != START_FIRST)
                begin
                    emit       = 1'b1;
                    res_status = ST_BAD_START;
                end
                else
                begin
                    long_frm_next = long_cfg_reg;
                    sum_next      = {8'h00, s_tdata};
                    pos_next      = 6'd1;
                end
            end
            else if (pos_reg == 6'd1)
            begin
                pos_next = 6'd0;
                if (s_tuser)
                begin
                    emit       = 1'b1;
                    res_status = ST_RX_ERR;
                end
                else if (s_tdata != START_SECOND)
                begin
                    emit       = 1'b1;
                    res_status = ST_BAD_START;
                end
                else
                begin
                    sum_next = sum_reg + {8'h00, s_tdata};
                    pos_next = 6'd2;
                end
            end
            else if (!s_tuser)
            begin
                // check word bytes stay out of the sum
                if (pos_reg < frame_len - 6'd2)
                begin
                    sum_next = sum_reg + {8'h00, s_tdata};
                end

                if (!pos_reg[0])
                begin
                    hold_next = s_tdata;
                end
                else if (pos_reg == 6'd3)
                begin
                    length_next = word;
                end
                else if (pos_reg >= 6'd5 && pos_reg <= 6'd15)
                begin
                    for (int i = 0; i < NUM_WORDS; i++)
                    begin
                        if (word_idx == 3'(i))
                        begin
                            words_next[i] = word;
                        end
                    end
                end

                if (pos_reg == frame_len - 6'd1)
                begin
                    pos_next = 6'd0;
                    emit     = 1'b1;
                    // length error wins over checksum error
                    if (length_reg != {10'd0, frame_len - 6'd4})
                    begin
                        res_status = ST_BAD_LEN;
                    end
                    else if (sum_reg != word)
                    begin
                        res_status    = ST_BAD_SUM;
                        res_with_data = 1'b1;
                    end
                    else
                    begin
                        res_status    = ST_OK;
                        res_with_data = 1'b1;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_data_next   = res_with_data ? words_flat : '0;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_cfg_reg  <= 1'b1;
            long_frm_reg  <= 1'b1;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            long_cfg_reg  <= long_cfg_next;
            long_frm_reg  <= long_frm_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        length_reg     <= length_next;
        hold_reg       <= hold_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            words_reg[i] <= words_next[i];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== design/psfp_checker.sv =====
// ----------------------------------------------------------------------------
// psfp_checker
// Port-level checks for the particle sensor frame parser.
// ----------------------------------------------------------------------------
`include "particle_sensor_frame_parser_defines.svh"

module psfp_checker
    import psfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_data
);

    // stalled result holds
    `PSFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // error results other than checksum carry no readings
    `PSFP_ASSERT_SAME(a_err_zero, m_tvalid && (m_tuser == ST_RX_ERR || m_tuser == ST_BAD_START || m_tuser == ST_BAD_LEN), m_tdata == '0, "error result with readings")

    // input only held off by a waiting result
    `PSFP_ASSERT_SAME(a_in_free, !m_tvalid || m_tready, s_tready, "input stalled with free output")

    // config port never pushes back
    `PSFP_ASSERT_SAME(a_cfg_rdy, 1'b1, cfg_ready, "config port not ready")

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: particle sensor frame parser testbench
// Drives received bytes and receive timeouts into the parser and checks every
// frame/error result against a cycle-free model of the parser kept in here.
// Short directed hunt cases, then four random phases that alternate the
// 24-byte and 32-byte frame lengths.
// ----------------------------------------------------------------------------
module tb;
    import psfp_pkg::*;

    localparam int STALL_LIMIT  = 500;  // cycles with no handshake at all
    localparam int PHASE_ITEMS  = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_t;

    // one request on the byte side
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_timeout;
    } rx_req_t;

    // one expected result: status plus the six readings, reading 0 lowest
    typedef struct packed {
        status_t                          status;
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    } frame_result_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'h00;    // [7:0] rx_byte
    logic         s_tuser   = 1'b0;     // [0] rx_timeout
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [95:0]  m_tdata;              // [15:0] pm1_indoor .. [95:80] pm10_outdoor
    logic [2:0]   m_tuser;              // [2:0] status
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data  = 1'b0;     // long_frame

    // stimulus and scoreboard
    rx_req_t       byte_queue[$];       // requests waiting for the driver
    frame_result_t frame_results[$];    // results the parser still owes us
    int            mismatch_count = 0;
    int            queued_in_phase = 0;
    int            send_gap = 0, send_calm = 0;
    int            hold_left = 0, hold_calm = 0;

    string word_name [NUM_WORDS] = '{"pm1_indoor", "pm25_indoor", "pm10_indoor",
                                     "pm1_outdoor", "pm25_outdoor", "pm10_outdoor"};

    // parser model state
    logic             long_sel;
    logic [POS_W-1:0] frame_len;        // latched at the first start byte
    logic [POS_W-1:0] parse_pos;        // 0 = hunting the first start byte
    logic [15:0]      run_sum;
    logic [15:0]      len_word;
    logic [15:0]      check_word;
    logic [7:0]       hold_byte;
    logic [15:0]      rd_words [NUM_WORDS];

    particle_sensor_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Parser model. Consumes one accepted request, returns 1 when the parser
    // owes a result for it.
    // ------------------------------------------------------------------------
    function automatic bit parse_byte(input logic [7:0] b, input logic tmo,
                                      output frame_result_t res);
        int          p, len, i;
        logic [15:0] word;
        p   = parse_pos;
        len = frame_len;
        res = '0;
        // hunting the first start byte: a timeout or any other byte is reported
        if (p == 0)
        begin
            if (tmo)
            begin
                res.status = ST_RX_ERR;
                return 1'b1;
            end
            if (b != START_FIRST)
            begin
                res.status = ST_BAD_START;
                return 1'b1;
            end
            frame_len = long_sel ? LONG_LEN : SHORT_LEN;
            run_sum   = {8'h00, b};
            parse_pos = 6'd1;
            return 1'b0;
        end
        // second start byte: any outcome other than 0x4D drops back to hunting
        if (p == 1)
        begin
            parse_pos = 6'd0;
            if (tmo)
            begin
                res.status = ST_RX_ERR;
                return 1'b1;
            end
            if (b != START_SECOND)
            begin
                res.status = ST_BAD_START;
                return 1'b1;
            end
            run_sum   = run_sum + b;
            parse_pos = 6'd2;
            return 1'b0;
        end
        // inside the frame a timeout is simply dropped
        if (tmo)
            return 1'b0;
        if (p < len - 2)
            run_sum = run_sum + b;
        if (p % 2 == 0)
        begin
            hold_byte = b;
        end
        else
        begin
            word = {hold_byte, b};
            if (p == 3)
                len_word = word;
            else if (p >= 5 && p <= 15)
                rd_words[(p - 5) / 2] = word;
            if (p == len - 1)
                check_word = word;
        end
        if (p + 1 >= len)
        begin
            parse_pos = 6'd0;
            // length is judged first; its result carries no readings
            if (int'(len_word) != len - 4)
            begin
                res.status = ST_BAD_LEN;
            end
            else
            begin
                res.status = (run_sum != check_word) ? ST_BAD_SUM : ST_OK;
                for (i = 0; i < NUM_WORDS; i++)
                    res.words[i] = rd_words[i];
            end
            return 1'b1;
        end
        parse_pos = POS_W'(p + 1);
        return 1'b0;
    endfunction

    // random per-request wait, with runs of back-to-back traffic
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Byte driver: one request at a time from byte_queue, random gap after
    // each. The model sees a request at the edge where it is accepted.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_driver
        rx_req_t       req;
        frame_result_t res;
        bit            owes;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                owes = parse_byte(s_tdata, s_tuser, res);
                if (owes)
                    frame_results.push_back(res);
            end
            // slot is free once the current request has gone (or none is up)
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    req = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.rx_byte;
                    s_tuser  <= req.rx_timeout;
                    send_gap = draw_wait(send_calm);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest one owed,
    // field by field, then hold m_tready low for a random stall.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        frame_result_t want;
        int            w;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_results.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result, status %0d", m_tuser));
                end
                else
                begin
                    want = frame_results.pop_front();
                    if (m_tuser !== want.status)
                        note_mismatch($sformatf("status: got %0d, want %0d",
                                                m_tuser, want.status));
                    for (w = 0; w < NUM_WORDS; w++)
                        if (m_tdata[w*WORD_W +: WORD_W] !== want.words[w])
                            note_mismatch($sformatf("%s: got %h, want %h", word_name[w],
                                                    m_tdata[w*WORD_W +: WORD_W],
                                                    want.words[w]));
                end
                hold_left = draw_wait(hold_calm);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no handshake of any kind happens for too long.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [7:0] b, input logic tmo);
        rx_req_t req;
        req.rx_byte    = b;
        req.rx_timeout = tmo;
        byte_queue.push_back(req);
        queued_in_phase++;
    endtask

    // Whole frame of nbytes with optional wrong length word, wrong checksum
    // and timeouts sprinkled inside (the parser should drop those).
    task automatic push_frame(input int nbytes, input bit bad_len, input bit bad_sum,
                              input int timeouts, input fill_t fill);
        logic [7:0]  fb [32];
        logic [15:0] sum, lw;
        int          i;
        lw = 16'(nbytes - 4);
        if (bad_len)
            lw = lw ^ (16'd1 << $urandom_range(0, 15));
        fb[0] = START_FIRST;
        fb[1] = START_SECOND;
        fb[2] = lw[15:8];
        fb[3] = lw[7:0];
        for (i = 4; i < nbytes - 2; i++)
            fb[i] = (fill == FILL_ONES)  ? 8'hFF :
                    (fill == FILL_ZEROS) ? 8'h00 : 8'($urandom);
        sum = '0;
        for (i = 0; i < nbytes - 2; i++)
            sum = sum + fb[i];
        if (bad_sum)
            sum = sum ^ (16'd1 << $urandom_range(0, 15));
        fb[nbytes-2] = sum[15:8];
        fb[nbytes-1] = sum[7:0];
        for (i = 0; i < nbytes; i++)
        begin
            if (i >= 2 && timeouts > 0 && $urandom_range(0, 5) == 0)
            begin
                push_item(8'($urandom), 1'b1);
                timeouts--;
            end
            push_item(fb[i], 1'b0);
        end
    endtask

    // wait until every request is in and every owed result is out
    task automatic wait_drained();
        @(negedge clk);
        while (byte_queue.size() != 0 || s_tvalid || frame_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_frame_length(input logic long_req);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= long_req;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        long_sel = long_req;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly clean frames with random content; the rest is line noise,
    // timeouts while hunting, broken start pairs and frames of the wrong size.
    task automatic queue_random_traffic(input int target);
        int         pick, kind, nlen, other, i;
        logic [7:0] b;
        nlen = long_sel ? LONG_LEN : SHORT_LEN;
        queued_in_phase = 0;
        // fixed openers: saturated readings, length error
        // masking a checksum error, and a plain bad checksum
        push_frame(nlen, 1'b0, 1'b0, 2, FILL_ONES);
        push_frame(nlen, 1'b1, 1'b1, 0, FILL_ZEROS);
        push_frame(nlen, 1'b0, 1'b1, 0, FILL_RANDOM);
        while (queued_in_phase < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                kind = $urandom_range(0, 19);
                push_frame(nlen, kind < 2 || kind == 4, kind >= 2 && kind <= 4,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                           fill_t'(($urandom_range(0, 9) < 2) ? $urandom_range(1, 2) : 0));
            end
            else if (pick < 80)
            begin
                for (i = $urandom_range(1, 4); i > 0; i--)
                    push_item(8'($urandom), 1'b0);
                push_item(8'($urandom), 1'b1);     // reported unless a frame just began
            end
            else if (pick < 88)
            begin
                for (i = $urandom_range(1, 2); i > 0; i--)
                    push_item(8'($urandom), 1'b1);
            end
            else if (pick < 95)
            begin
                push_item(START_FIRST, 1'b0);
                if ($urandom_range(0, 1) == 0)
                begin
                    push_item(8'($urandom), 1'b1);
                end
                else
                begin
                    do
                        b = 8'($urandom);
                    while (b == START_SECOND);
                    push_item(b, 1'b0);
                end
            end
            else
            begin
                // frame built for the other length: short one gets padded out
                other = LONG_LEN + SHORT_LEN - nlen;
                push_frame(other, 1'b0, 1'b0, 0, FILL_RANDOM);
                for (i = other; i < nlen; i++)
                    push_item(8'($urandom), 1'b0);
                push_item(8'($urandom), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int ph;
        long_sel   = 1'b1;
        frame_len  = LONG_LEN;
        parse_pos  = '0;
        run_sum    = '0;
        len_word   = '0;
        check_word = '0;
        hold_byte  = '0;
        for (ph = 0; ph < NUM_WORDS; ph++)
            rd_words[ph] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_frame_length(1'b1);

        // hunt cases: timeouts at both start bytes (even carrying a start byte
        // value), wrong first byte at both extremes, wrong second byte, and a
        // repeated first start byte
        push_item(8'h00, 1'b1);
        push_item(START_FIRST, 1'b1);
        push_item(START_FIRST, 1'b0);
        push_item(START_SECOND, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(START_FIRST, 1'b0);
        push_item(8'h4C, 1'b0);
        push_item(START_FIRST, 1'b0);
        push_item(START_FIRST, 1'b0);
        push_item(START_SECOND, 1'b0);

        // random phases, frame length alternating between short and long
        for (ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            repeat (4) @(posedge clk);
            set_frame_length(ph % 2 == 1);
            queue_random_traffic(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (frame_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", frame_results.size()));
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/psfp_pkg.sv
design/particle_sensor_frame_parser.sv
design/psfp_checker.sv
tb/tb.sv
